// ----- rtl/tms_pkg.sv -----
// Shared types and constants for the trimmed-mean smoother.
// No dependencies; imported by every tms_* module and the top level.
`default_nettype none

package tms_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

// ----- rtl/tms_window.sv -----
// Sample window: shift register of the last WINDOW_LEN samples, cleared at reset.
// Depends on tms_pkg. The window contents double as the first pipeline register.
`default_nettype none

module tms_window #(
  parameter int WINDOW_LEN = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tms_pkg::sample_t sample,
  output logic             out_valid,
  input  logic             out_ready,
  output tms_pkg::sample_t window [WINDOW_LEN]
);
  import tms_pkg::*;

  assign in_ready = !out_valid || out_ready;

  // entry 0 is the oldest, the last entry the newest
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[WINDOW_LEN-1] <= sample;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tms_trim_sum.sv -----
// Rank-based trim and sum: every entry gets its rank by parallel compares,
// entries with rank in [TRIM, WINDOW_LEN-1-TRIM] are summed. Depends on tms_pkg.
`default_nettype none

module tms_trim_sum #(
  parameter int WINDOW_LEN = 5,
  parameter int TRIM       = 1,
  parameter int SUM_W      = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tms_pkg::sample_t        window [WINDOW_LEN],
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] sum
);
  import tms_pkg::*;

  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam logic [RANK_W-1:0] RANK_LO = RANK_W'(TRIM);
  localparam logic [RANK_W-1:0] RANK_HI = RANK_W'(WINDOW_LEN - 1 - TRIM);

  logic [RANK_W-1:0]       rank [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]   kept;
  logic signed [SUM_W-1:0] sum_next;

  // ties broken by position, so the ranks form a permutation
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          if (window[j] < window[i] || (window[j] == window[i] && j < i)) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
      kept[i] = (rank[i] >= RANK_LO) && (rank[i] <= RANK_HI);
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (kept[i]) begin
        sum_next = sum_next + SUM_W'(window[i]);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tms_const_div.sv -----
// Division of the trimmed sum by the constant kept count, truncating toward zero.
// Magnitude times a rounded-up reciprocal, exact for all sums. Depends on tms_pkg.
`default_nettype none

module tms_const_div #(
  parameter int SUM_W   = 19,
  parameter int DIVISOR = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SUM_W-1:0] sum,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tms_pkg::sample_t        quotient
);
  import tms_pkg::*;

  // extra 5 fractional bits cover ceil(log2(DIVISOR)) for divisors up to 16
  localparam int SHIFT   = SUM_W + 5;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QUO_W   = SAMPLE_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] quo_signed;

  always_comb begin
    neg        = sum[SUM_W-1];
    mag        = neg ? SUM_W'(-sum) : SUM_W'(sum);
    prod       = PROD_W'(mag) * PROD_W'(RECIP);
    quo        = prod[SHIFT +: QUO_W];
    quo_signed = neg ? (~quo + 1'b1) : quo;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      quotient <= sample_t'(quo_signed[SAMPLE_W-1:0]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/trimmed_mean_smoother.sv -----
// Trimmed-mean smoother top level: window, trim/sum and constant-divide stages.
// Depends on tms_pkg, tms_window, tms_trim_sum, tms_const_div.
//
//   channel   | signals                              | dir
//   ----------+--------------------------------------+-----
//   sample    | sample_valid, sample_ready, sample   | in
//   smoothed  | smoothed_valid, smoothed_ready,      | out
//             | smoothed                             |
//
// One item per cycle sustained while smoothed_ready is high; a result moves from the
// window register (loaded on the edge taking its sample) via the sum register to the result register.
// Reset clears the window to zero and empties all three stages.
// A stall on smoothed_ready holds each full stage; sample_ready stays high
// as long as some stage is empty or smoothed_ready is high.
`default_nettype none

module trimmed_mean_smoother #(
  parameter int WINDOW_LEN     = 5,
  parameter int TRIM_EACH_SIDE = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  tms_pkg::sample_t sample,
  output logic             smoothed_valid,
  input  logic             smoothed_ready,
  output tms_pkg::sample_t smoothed
);
  import tms_pkg::*;

  localparam int TRIM_MAX = (WINDOW_LEN - 1) / 2;
  localparam int TRIM     = (TRIM_EACH_SIDE > TRIM_MAX) ? TRIM_MAX : TRIM_EACH_SIDE;
  localparam int KEEP     = WINDOW_LEN - 2 * TRIM;
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN);

  sample_t                 window [WINDOW_LEN];
  logic                    win_valid;
  logic                    sum_ready;
  logic                    sum_valid;
  logic                    div_ready;
  logic signed [SUM_W-1:0] sum;

  tms_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_valid),
    .in_ready (sample_ready),
    .sample   (sample),
    .out_valid(win_valid),
    .out_ready(sum_ready),
    .window   (window)
  );

  tms_trim_sum #(
    .WINDOW_LEN(WINDOW_LEN),
    .TRIM      (TRIM),
    .SUM_W     (SUM_W)
  ) u_trim_sum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (win_valid),
    .in_ready (sum_ready),
    .window   (window),
    .out_valid(sum_valid),
    .out_ready(div_ready),
    .sum      (sum)
  );

  tms_const_div #(
    .SUM_W  (SUM_W),
    .DIVISOR(KEEP)
  ) u_const_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sum_valid),
    .in_ready (div_ready),
    .sum      (sum),
    .out_valid(smoothed_valid),
    .out_ready(smoothed_ready),
    .quotient (smoothed)
  );

  // a free output slot must propagate room back through every stage
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!smoothed_valid || smoothed_ready) |-> sample_ready)
    else $error("sample_ready low although the output stage can move");

  // an accepted sample lands as the newest window entry
  a_window_load: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=>
      (win_valid && window[WINDOW_LEN-1] == $past(sample)))
    else $error("accepted item not loaded into the window");

  // a stalled window stage must keep its oldest and newest entries and stay valid
  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    (win_valid && !sum_ready) |=>
      ($stable(window[WINDOW_LEN-1]) && $stable(window[0]) && win_valid))
    else $error("window changed while its stage was stalled");

endmodule

`default_nettype wire
